/* rtl/spi_pkg.sv */
// shared constants and codes for the segment plane intersection unit
package spi_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TOL_W      = 31;

  // tolerance alignment for the parallel test (Q32) and straddle test (Q64)
  localparam int TOL_PAR_SHIFT = 16;
  localparam int TOL_STR_SHIFT = 48;

  localparam logic [CFG_DATA_W-1:0] NORMAL_Y_RST = 32'h0001_0000;
  localparam logic [TOL_W-1:0]      TOL_RST      = 31'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_NORMAL_X  = 3'd3,
    REG_NORMAL_Y  = 3'd4,
    REG_NORMAL_Z  = 3'd5,
    REG_TOLERANCE = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_HIT      = 2'd0,
    STAT_PARALLEL = 2'd1,
    STAT_NO_CROSS = 2'd2
  } status_e;

endpackage

/* rtl/spi_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module spi_div #(
  parameter int DEN_W = 67,
  parameter int QUO_W = 33
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DEN_W+QUO_W-1:0]   num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [QUO_W-1:0]         quo_o,
  output logic                     ovf_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [QUO_W:0]   ovf_q;

  logic [DEN_W:0]   trial [QUO_W];
  logic [QUO_W-1:0] ge;
  logic [DEN_W-1:0] rem_d [QUO_W];

  always_comb begin
    for (int s = 0; s < QUO_W; s++) begin
      trial[s] = {rem_q[s], low_q[s][QUO_W-1]};
      ge[s]    = trial[s] >= {1'b0, den_q[s]};
      rem_d[s] = ge[s] ? DEN_W'(trial[s] - {1'b0, den_q[s]}) : DEN_W'(trial[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // top part of the numerator must stay below the divisor
      rem_q[0] <= num_i[DEN_W+QUO_W-1:QUO_W];
      low_q[0] <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= num_i[DEN_W+QUO_W-1:QUO_W] >= den_i;
      for (int s = 0; s < QUO_W; s++) begin
        quo_q[s+1]  <= {quo_q[s][QUO_W-2:0], ge[s]};
        ovf_q[s+1]  <= ovf_q[s];
        if (s + 1 < QUO_W) begin
          rem_q[s+1] <= rem_d[s];
          low_q[s+1] <= low_q[s] << 1;
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

/* rtl/segment_plane_intersection_unit.sv */
// top level: line and segment intersection with a configured plane, Q16.16
//
// usage
//   in channel (in_valid_i / in_ready_o) takes one word per cycle while in_ready_o
//   is high: an action and two points. action 0 reads A as line origin and B as
//   direction, action 1 reads A and B as segment endpoints.
//   out channel (out_valid_o / out_ready_i) gives one word per input word,
//   in order: status (hit, parallel, no cross) and the crossing point,
//   which is zero unless the status is hit.
//   cfg channel writes plane origin, normal and tolerance by index; it is
//   always ready. the user must write it only while no word is in flight; the block itself has no check for it.
// throughput
//   one word per cycle sustained while the output is not stalled. the depth is
//   set by the divider, which resolves one quotient bit per stage over
//   COORD_WIDTH+1 stages.
// reset
//   clears every valid bit and loads the plane y=0 with normal (0, 1.0, 0)
//   and tolerance 2^-16.
// stall
//   an output register plus a skid register sit at the tail; in_ready_o
//   falls only once both are full, and the whole pipe then holds in place.
module segment_plane_intersection_unit
  import spi_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o,
  output logic signed [COORD_WIDTH-1:0] cross_z_o
);

  localparam int W   = COORD_WIDTH;
  localparam int VW  = W + 1;          // point differences
  localparam int MW  = 2 * W + 1;      // difference times normal
  localparam int DW  = 2 * W + 3;      // dot products, Q32
  localparam int LW  = (DW + 1) / 2;   // low half for split multiplies
  localparam int HW  = DW - LW;
  localparam int NW  = VW + DW;        // numerator magnitude
  localparam int QW  = W + 1;          // quotient bits before clamping
  localparam int CW  = W + 3;          // point plus quotient
  localparam int EW  = 2 * W + 2;      // containment products
  localparam int ESW = 2 * W + 4;
  localparam int PW  = (DW > TOL_W + TOL_PAR_SHIFT) ? DW : TOL_W + TOL_PAR_SHIFT;
  localparam int SW  = (2 * DW > TOL_W + TOL_STR_SHIFT) ? 2 * DW : TOL_W + TOL_STR_SHIFT;
  localparam int NST = QW + 9;         // pipeline registers ahead of the output stage

  typedef struct packed {
    logic              act;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
  } base_t;

  typedef struct packed {
    base_t      base;
    logic       par;
    logic [2:0] q_neg;
    logic       str_ok;
  } side_t;

  // ---------------------------------------------------------------- config
  logic signed [W-1:0] origin_q [3];
  logic signed [W-1:0] normal_q [3];
  logic [TOL_W-1:0]    tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      normal_q[0] <= '0;
      normal_q[1] <= W'(NORMAL_Y_RST);
      normal_q[2] <= '0;
      tol_q       <= TOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:  origin_q[0] <= W'(cfg_data_i);
        REG_ORIGIN_Y:  origin_q[1] <= W'(cfg_data_i);
        REG_ORIGIN_Z:  origin_q[2] <= W'(cfg_data_i);
        REG_NORMAL_X:  normal_q[0] <= W'(cfg_data_i);
        REG_NORMAL_Y:  normal_q[1] <= W'(cfg_data_i);
        REG_NORMAL_Z:  normal_q[2] <= W'(cfg_data_i);
        REG_TOLERANCE: tol_q       <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic           en;
  logic [NST-1:0] vld_q;
  logic           skid_v_q;

  // the pipe moves as a whole; it only holds when the skid register is full
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // differences to the plane origin and the line direction
  logic signed [W-1:0]  pt_a [3];
  logic signed [W-1:0]  pt_b [3];
  logic signed [VW-1:0] pa_d [3];
  logic signed [VW-1:0] pb_d [3];
  logic signed [VW-1:0] dir_d [3];
  base_t                base_d;

  assign pt_a[0] = point_a_x_i;
  assign pt_a[1] = point_a_y_i;
  assign pt_a[2] = point_a_z_i;
  assign pt_b[0] = point_b_x_i;
  assign pt_b[1] = point_b_y_i;
  assign pt_b[2] = point_b_z_i;

  always_comb begin
    base_d.act = action_i;
    for (int i = 0; i < 3; i++) begin
      base_d.a[i] = pt_a[i];
      base_d.b[i] = pt_b[i];
      pa_d[i]  = VW'(pt_a[i]) - VW'(origin_q[i]);
      // for a line, B is a direction: its dot with the normal is taken as is
      pb_d[i]  = action_i ? VW'(pt_b[i]) - VW'(origin_q[i]) : VW'(pt_b[i]);
      dir_d[i] = action_i ? VW'(pt_b[i]) - VW'(pt_a[i]) : VW'(pt_b[i]);
    end
  end

  base_t                base1_q;
  logic signed [VW-1:0] pa1_q [3];
  logic signed [VW-1:0] pb1_q [3];
  logic signed [VW-1:0] dir1_q [3];

  // ---------------------------------------------------------------- stage 2
  base_t                base2_q;
  logic signed [VW-1:0] dir2_q [3];
  logic signed [MW-1:0] ma2_q [3];
  logic signed [MW-1:0] mb2_q [3];

  // ---------------------------------------------------------------- stage 3
  base_t                base3_q;
  logic signed [VW-1:0] dir3_q [3];
  logic signed [DW-1:0] d1_3_q;
  logic signed [DW-1:0] d2_3_q;

  // ---------------------------------------------------------------- stage 4
  // fa = -d1, fb = N.dir which for a segment is d2 - d1
  logic signed [DW-1:0] fb_d;
  logic [DW-1:0]        fa_mag_d;
  logic [DW-1:0]        d2_mag_d;
  logic [VW-1:0]        dir_mag_d [3];

  always_comb begin
    fb_d     = base3_q.act ? d2_3_q - d1_3_q : d2_3_q;
    fa_mag_d = d1_3_q[DW-1] ? DW'(-d1_3_q) : DW'(d1_3_q);
    d2_mag_d = d2_3_q[DW-1] ? DW'(-d2_3_q) : DW'(d2_3_q);
    for (int i = 0; i < 3; i++) begin
      dir_mag_d[i] = dir3_q[i][VW-1] ? VW'(-dir3_q[i]) : VW'(dir3_q[i]);
    end
  end

  base_t                base4_q;
  logic signed [DW-1:0] fb4_q;
  logic [DW-1:0]        fa_mag4_q;
  logic                 fa_neg4_q;
  logic [DW-1:0]        d2_mag4_q;
  logic                 str_neg4_q;
  logic [VW-1:0]        dir_mag4_q [3];
  logic [2:0]           dir_neg4_q;

  // ---------------------------------------------------------------- stage 5
  // parallel test and split partial products
  logic [DW-1:0] fb_mag_d;
  logic          par_d;

  always_comb begin
    fb_mag_d = fb4_q[DW-1] ? DW'(-fb4_q) : DW'(fb4_q);
    // an exact zero divisor is parallel even at zero tolerance
    par_d    = (fb4_q == '0) ||
               (PW'(fb_mag_d) < (PW'(tol_q) << TOL_PAR_SHIFT));
  end

  base_t                 base5_q;
  logic [DW-1:0]         fb_mag5_q;
  logic                  par5_q;
  logic [2:0]            q_neg5_q;
  logic                  str_neg5_q;
  logic [VW+LW-1:0]      num_lo5_q [3];
  logic [VW+HW-1:0]      num_hi5_q [3];
  logic [2*LW-1:0]       p_ll5_q;
  logic [LW+HW-1:0]      p_lh5_q;
  logic [LW+HW-1:0]      p_hl5_q;
  logic [2*HW-1:0]       p_hh5_q;

  // ---------------------------------------------------------------- stage 6
  base_t         base6_q;
  logic [DW-1:0] fb_mag6_q;
  logic          par6_q;
  logic [2:0]    q_neg6_q;
  logic          str_neg6_q;
  logic [NW-1:0] num6_q [3];
  logic [SW-1:0] prod6_q;

  // ---------------------------------------------------------------- divider
  side_t         side_d;
  side_t         side_q [QW+1];
  logic [QW-1:0] quo [3];
  logic [2:0]    ovf;

  always_comb begin
    side_d.base  = base6_q;
    side_d.par   = par6_q;
    side_d.q_neg = q_neg6_q;
    // distance product below tolerance; a negative product always passes
    side_d.str_ok = str_neg6_q || (prod6_q < (SW'(tol_q) << TOL_STR_SHIFT));
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    spi_div #(
      .DEN_W (DW),
      .QUO_W (QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num6_q[g]),
      .den_i (fb_mag6_q),
      .quo_o (quo[g]),
      .ovf_o (ovf[g])
    );
  end

  // ---------------------------------------------------------------- stage 7
  // crossing = A + signed quotient, saturated; an overflowed quotient
  // is clamped to a size that always saturates
  logic [QW:0]          q_mag_d [3];
  logic signed [CW-1:0] q_sgn_d [3];
  logic signed [CW-1:0] sum_d [3];
  logic [W-1:0]         c_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_mag_d[i] = ovf[i] ? ((QW+1)'(1) << QW) : (QW+1)'(quo[i]);
      q_sgn_d[i] = side_q[QW].q_neg[i] ? -CW'(q_mag_d[i]) : CW'(q_mag_d[i]);
      sum_d[i]   = CW'($signed(side_q[QW].base.a[i])) + q_sgn_d[i];
      if (sum_d[i][CW-1:W-1] == '0 || sum_d[i][CW-1:W-1] == '1) begin
        c_d[i] = W'(sum_d[i]);
      end else if (sum_d[i][CW-1]) begin
        c_d[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        c_d[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  base_t      base7_q;
  logic       par7_q;
  logic       str_ok7_q;
  logic [W-1:0] c7_q [3];

  // ---------------------------------------------------------------- stage 8
  // (A-C).(B-C) terms for the strictly-inside check
  logic signed [VW-1:0] ea_d [3];
  logic signed [VW-1:0] eb_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea_d[i] = VW'($signed(base7_q.a[i])) - VW'($signed(c7_q[i]));
      eb_d[i] = VW'($signed(base7_q.b[i])) - VW'($signed(c7_q[i]));
    end
  end

  logic                 act8_q;
  logic                 par8_q;
  logic                 str_ok8_q;
  logic [W-1:0]         c8_q [3];
  logic signed [EW-1:0] e8_q [3];

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      base1_q <= base_d;
      for (int i = 0; i < 3; i++) begin
        pa1_q[i]  <= pa_d[i];
        pb1_q[i]  <= pb_d[i];
        dir1_q[i] <= dir_d[i];
      end
      // stage 2
      base2_q <= base1_q;
      for (int i = 0; i < 3; i++) begin
        dir2_q[i] <= dir1_q[i];
        ma2_q[i]  <= MW'(pa1_q[i]) * MW'(normal_q[i]);
        mb2_q[i]  <= MW'(pb1_q[i]) * MW'(normal_q[i]);
      end
      // stage 3
      base3_q <= base2_q;
      for (int i = 0; i < 3; i++) begin
        dir3_q[i] <= dir2_q[i];
      end
      d1_3_q <= DW'(ma2_q[0]) + DW'(ma2_q[1]) + DW'(ma2_q[2]);
      d2_3_q <= DW'(mb2_q[0]) + DW'(mb2_q[1]) + DW'(mb2_q[2]);
      // stage 4
      base4_q    <= base3_q;
      fb4_q      <= fb_d;
      fa_mag4_q  <= fa_mag_d;
      fa_neg4_q  <= !d1_3_q[DW-1];
      d2_mag4_q  <= d2_mag_d;
      str_neg4_q <= (d1_3_q[DW-1] ^ d2_3_q[DW-1]) && (d1_3_q != '0) && (d2_3_q != '0);
      for (int i = 0; i < 3; i++) begin
        dir_mag4_q[i] <= dir_mag_d[i];
        dir_neg4_q[i] <= dir3_q[i][VW-1];
      end
      // stage 5
      base5_q    <= base4_q;
      fb_mag5_q  <= fb_mag_d;
      par5_q     <= par_d;
      str_neg5_q <= str_neg4_q;
      for (int i = 0; i < 3; i++) begin
        q_neg5_q[i]  <= dir_neg4_q[i] ^ fa_neg4_q ^ fb4_q[DW-1];
        num_lo5_q[i] <= (VW+LW)'(dir_mag4_q[i]) * (VW+LW)'(fa_mag4_q[LW-1:0]);
        num_hi5_q[i] <= (VW+HW)'(dir_mag4_q[i]) * (VW+HW)'(fa_mag4_q[DW-1:LW]);
      end
      p_ll5_q <= (2*LW)'(fa_mag4_q[LW-1:0]) * (2*LW)'(d2_mag4_q[LW-1:0]);
      p_lh5_q <= (LW+HW)'(fa_mag4_q[LW-1:0]) * (LW+HW)'(d2_mag4_q[DW-1:LW]);
      p_hl5_q <= (LW+HW)'(fa_mag4_q[DW-1:LW]) * (LW+HW)'(d2_mag4_q[LW-1:0]);
      p_hh5_q <= (2*HW)'(fa_mag4_q[DW-1:LW]) * (2*HW)'(d2_mag4_q[DW-1:LW]);
      // stage 6
      base6_q    <= base5_q;
      fb_mag6_q  <= fb_mag5_q;
      par6_q     <= par5_q;
      q_neg6_q   <= q_neg5_q;
      str_neg6_q <= str_neg5_q;
      for (int i = 0; i < 3; i++) begin
        num6_q[i] <= NW'(num_lo5_q[i]) + (NW'(num_hi5_q[i]) << LW);
      end
      prod6_q <= SW'(p_ll5_q) + (SW'(p_lh5_q) << LW) + (SW'(p_hl5_q) << LW) +
                 (SW'(p_hh5_q) << (2 * LW));
      // side data alongside the divider
      side_q[0] <= side_d;
      for (int k = 1; k <= QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
      // stage 7
      base7_q   <= side_q[QW].base;
      par7_q    <= side_q[QW].par;
      str_ok7_q <= side_q[QW].str_ok;
      for (int i = 0; i < 3; i++) begin
        c7_q[i] <= c_d[i];
      end
      // stage 8
      act8_q    <= base7_q.act;
      par8_q    <= par7_q;
      str_ok8_q <= str_ok7_q;
      for (int i = 0; i < 3; i++) begin
        c8_q[i] <= c7_q[i];
        e8_q[i] <= EW'(ea_d[i]) * EW'(eb_d[i]);
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic signed [ESW-1:0] inside_sum;
  status_e               stat_d;
  logic [W-1:0]          cross_d [3];

  always_comb begin
    inside_sum = ESW'(e8_q[0]) + ESW'(e8_q[1]) + ESW'(e8_q[2]);
    if (!act8_q) begin
      stat_d = par8_q ? STAT_PARALLEL : STAT_HIT;
    end else if (!str_ok8_q) begin
      stat_d = STAT_NO_CROSS;
    end else if (par8_q) begin
      stat_d = STAT_PARALLEL;
    end else if (inside_sum[ESW-1]) begin
      stat_d = STAT_HIT;
    end else begin
      stat_d = STAT_NO_CROSS;
    end
    for (int i = 0; i < 3; i++) begin
      cross_d[i] = (stat_d == STAT_HIT) ? c8_q[i] : '0;
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic         push;
  logic         take;
  logic         out_v_q;
  status_e      out_stat_q;
  logic [W-1:0] out_cross_q [3];
  status_e      skid_stat_q;
  logic [W-1:0] skid_cross_q [3];

  assign push = en && vld_q[NST-1];
  assign take = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !take) begin
      // output held: a new word parks in the skid register
      if (push) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !take) begin
      if (push) begin
        skid_stat_q  <= stat_d;
        skid_cross_q <= cross_d;
      end
    end else if (skid_v_q) begin
      out_stat_q  <= skid_stat_q;
      out_cross_q <= skid_cross_q;
    end else if (push) begin
      out_stat_q  <= stat_d;
      out_cross_q <= cross_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_stat_q;
  assign cross_x_o   = out_cross_q[0];
  assign cross_y_o   = out_cross_q[1];
  assign cross_z_o   = out_cross_q[2];

endmodule

/* rtl/spi_checker.sv */
// port-level assertions for the segment plane intersection unit, bound to the top
module spi_checker
  import spi_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic signed [COORD_WIDTH-1:0] cross_x_o,
  input logic signed [COORD_WIDTH-1:0] cross_y_o,
  input logic signed [COORD_WIDTH-1:0] cross_z_o
);

  // a word that is not a hit carries a zero point
  a_cross_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_HIT) |->
      (cross_x_o == '0) && (cross_y_o == '0) && (cross_z_o == '0))
    else $error("crossing nonzero on a non-hit word");

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(cross_x_o) &&
      $stable(cross_y_o) && $stable(cross_z_o))
    else $error("output word changed while stalled");

  // input back-pressure only when the output side is full
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("in_ready low with empty output");

  // back-pressure holds until the receiver takes a word
  a_ready_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("in_ready rose without an output taken");

endmodule

bind segment_plane_intersection_unit spi_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_spi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .cross_x_o   (cross_x_o),
  .cross_y_o   (cross_y_o),
  .cross_z_o   (cross_z_o)
);

/* tb/spi_checker.sv */
// checker for the segment plane intersection unit: predicts every word and compares
`timescale 1ns / 100ps

module spi_scoreboard
  import spi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  action_i,
  input  logic signed [31:0]    point_a_x_i,
  input  logic signed [31:0]    point_a_y_i,
  input  logic signed [31:0]    point_a_z_i,
  input  logic signed [31:0]    point_b_x_i,
  input  logic signed [31:0]    point_b_y_i,
  input  logic signed [31:0]    point_b_z_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            status_i,
  input  logic signed [31:0]    cross_x_i,
  input  logic signed [31:0]    cross_y_i,
  input  logic signed [31:0]    cross_z_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } crossing_t;

  logic signed [31:0] plane_org [3];
  logic signed [31:0] plane_nrm [3];
  logic [TOL_W-1:0]   plane_tol;
  crossing_t          crossing_q[$];

  function automatic wide_t tol_wide();
    wide_t t;
    t = '0;
    t[TOL_W-1:0] = plane_tol;
    return t;
  endfunction

  function automatic wide_t signed_dist(input wide_t p [3]);
    wide_t s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s = s + (p[i] - wide_t'(plane_org[i])) * wide_t'(plane_nrm[i]);
    end
    return s;
  endfunction

  function automatic wide_t clamp32(input wide_t v);
    wide_t hi, lo;
    hi = wide_t'(32'sh7fff_ffff);
    lo = wide_t'(-32'sh7fff_ffff - 1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // returns 1 when the line is parallel to the plane
  function automatic bit solve_line(input wide_t a [3], input wide_t v [3],
                                    output wide_t c [3]);
    wide_t fa, fb, afb;
    fa = -signed_dist(a);
    fb = '0;
    for (int i = 0; i < 3; i++) begin
      c[i] = '0;
      fb = fb + wide_t'(plane_nrm[i]) * v[i];
    end
    afb = (fb < 0) ? -fb : fb;
    if (fb == 0 || afb < (tol_wide() <<< TOL_PAR_SHIFT)) return 1'b1;
    for (int i = 0; i < 3; i++) c[i] = clamp32(a[i] + (v[i] * fa) / fb);
    return 1'b0;
  endfunction

  function automatic crossing_t predict_crossing(input logic act,
      input logic signed [31:0] ax, ay, az, bx, by, bz);
    wide_t     a [3], b [3], v [3], c [3];
    wide_t     s;
    crossing_t r;
    a[0] = wide_t'(ax); a[1] = wide_t'(ay); a[2] = wide_t'(az);
    b[0] = wide_t'(bx); b[1] = wide_t'(by); b[2] = wide_t'(bz);
    for (int i = 0; i < 3; i++) c[i] = '0;
    if (!act) begin
      r.status = solve_line(a, b, c) ? STAT_PARALLEL : STAT_HIT;
    end else if (!((signed_dist(a) * signed_dist(b)) < (tol_wide() <<< TOL_STR_SHIFT))) begin
      r.status = STAT_NO_CROSS;
    end else begin
      for (int i = 0; i < 3; i++) v[i] = b[i] - a[i];
      r.status = solve_line(a, v, c) ? STAT_PARALLEL : STAT_HIT;
      if (r.status == STAT_HIT) begin
        s = '0;
        for (int i = 0; i < 3; i++) s = s + (a[i] - c[i]) * (b[i] - c[i]);
        if (s >= 0) r.status = STAT_NO_CROSS;
      end
    end
    if (r.status != STAT_HIT) for (int i = 0; i < 3; i++) c[i] = '0;
    r.cx = c[0][31:0];
    r.cy = c[1][31:0];
    r.cz = c[2][31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        plane_org[i] = '0;
        plane_nrm[i] = '0;
      end
      plane_nrm[1] = NORMAL_Y_RST;
      plane_tol    = TOL_RST;
      crossing_q.delete();
      errors_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:  plane_org[0] = cfg_data_i;
          REG_ORIGIN_Y:  plane_org[1] = cfg_data_i;
          REG_ORIGIN_Z:  plane_org[2] = cfg_data_i;
          REG_NORMAL_X:  plane_nrm[0] = cfg_data_i;
          REG_NORMAL_Y:  plane_nrm[1] = cfg_data_i;
          REG_NORMAL_Z:  plane_nrm[2] = cfg_data_i;
          REG_TOLERANCE: plane_tol    = cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        crossing_q.push_back(predict_crossing(action_i, point_a_x_i, point_a_y_i,
                                              point_a_z_i, point_b_x_i, point_b_y_i,
                                              point_b_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (crossing_q.size() == 0) begin
          $display("%0t unexpected word: status %0d cross %h %h %h", $realtime,
                   status_i, cross_x_i, cross_y_i, cross_z_i);
          errors_o++;
        end else begin
          e = crossing_q.pop_front();
          if (status_i !== e.status) begin
            $display("%0t status expected %0d actual %0d", $realtime, e.status, status_i);
            errors_o++;
          end
          if (cross_x_i !== e.cx) begin
            $display("%0t cross_x expected %h actual %h", $realtime, e.cx, cross_x_i);
            errors_o++;
          end
          if (cross_y_i !== e.cy) begin
            $display("%0t cross_y expected %h actual %h", $realtime, e.cy, cross_y_i);
            errors_o++;
          end
          if (cross_z_i !== e.cz) begin
            $display("%0t cross_z expected %h actual %h", $realtime, e.cz, cross_z_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = crossing_q.size();
  end

endmodule

/* tb/tb_segment_plane_intersection_unit.sv */
// testbench top for the segment plane intersection unit: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_segment_plane_intersection_unit;
  import spi_pkg::*;

  // index past the last register, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam logic signed [31:0]   Q_ONE         = 32'sh0001_0000;
  localparam logic signed [31:0]   Q_MAX         = 32'sh7fff_ffff;
  localparam logic signed [31:0]   Q_MIN         = 32'sh8000_0000;
  localparam int                   DRAIN_CYCLES  = 60;
  localparam int                   RAND_PER_PHASE = 320;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  action_i = 1'b0;
  logic signed [31:0]    point_a_x_i = '0;
  logic signed [31:0]    point_a_y_i = '0;
  logic signed [31:0]    point_a_z_i = '0;
  logic signed [31:0]    point_b_x_i = '0;
  logic signed [31:0]    point_b_y_i = '0;
  logic signed [31:0]    point_b_z_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic signed [31:0]    cross_x_o;
  logic signed [31:0]    cross_y_o;
  logic signed [31:0]    cross_z_o;
  int                    errors;
  int                    pending;
  int                    burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_plane_intersection_unit #(.COORD_WIDTH(32)) dut (.*);

  spi_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .point_a_x_i, .point_a_y_i,
    .point_a_z_i, .point_b_x_i, .point_b_y_i, .point_b_z_i, .out_valid_i(out_valid_o),
    .out_ready_i, .status_i(status_o), .cross_x_i(cross_x_o), .cross_y_i(cross_y_o),
    .cross_z_i(cross_z_o), .errors_o(errors), .pending_o(pending)
  );

  // receiver: the stall style is redrawn whenever its random hold count runs out
  always @(posedge clk_i) begin
    int mode_left;
    int mode;
    if (mode_left <= 0) begin
      mode_left = $urandom_range(50, 300);
      mode      = $urandom_range(0, 2);
    end
    mode_left--;
    case (mode)
      0:       out_ready_i <= 1'b1;                          // no stalls
      1:       out_ready_i <= 1'($urandom_range(0, 1));      // coin flip
      default: out_ready_i <= ($urandom_range(0, 9) < 2);    // mostly stalled
    endcase
  end

  // mostly small values so lines and segments actually hit the plane,
  // with full random words and the extremes mixed in
  function automatic logic signed [31:0] pick_coord();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return $signed($urandom_range(0, 2097152)) - 1048576;
    if (m < 8) return $urandom;
    case ($urandom_range(0, 4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return 32'sd1;
      3:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one word on the in channel, bursts with random gaps between them
  task automatic send_word(input logic act, input logic signed [31:0] ax, ay, az,
                           bx, by, bz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    point_a_x_i <= ax;
    point_a_y_i <= ay;
    point_a_z_i <= az;
    point_b_x_i <= bx;
    point_b_y_i <= by;
    point_b_z_i <= bz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic signed [31:0] ax, ay, az;
    ax = pick_coord();
    ay = pick_coord();
    az = pick_coord();
    if ($urandom_range(0, 3) == 0) begin
      send_word(1'b0, ax, ay, az, pick_coord(), pick_coord(), pick_coord());
    end else begin
      send_word(1'b1, ax, ay, az, pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // idle the in channel and let every word in flight come out
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic signed [31:0] n [3];
    int                 axis;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words against the reset plane y = 0, tolerance 2^-16
    send_word(1'b0, Q_ONE, 5 * Q_ONE, 2 * Q_ONE, 0, Q_ONE, 0);         // line hit
    send_word(1'b0, Q_ONE, 5 * Q_ONE, 2 * Q_ONE, Q_ONE, 0, Q_ONE);     // parallel line
    send_word(1'b0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0);                     // zero direction
    send_word(1'b0, 3, -7, 11, 13, 1, -5);                             // tiny direction
    send_word(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, Q_MIN);             // saturating crossing
    send_word(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
    send_word(1'b1, 0, -Q_ONE, 0, 2 * Q_ONE, Q_ONE, 2 * Q_ONE);        // segment crosses
    send_word(1'b1, 0, Q_ONE, 0, Q_ONE, 2 * Q_ONE, 0);                 // same side
    send_word(1'b1, 0, 0, 0, Q_ONE, 0, Q_ONE);                         // lies in the plane
    send_word(1'b1, Q_ONE, 0, 0, Q_ONE, Q_ONE, 0);                     // endpoint on plane
    send_word(1'b1, 0, -Q_ONE, 0, 0, -Q_ONE, 0);                       // degenerate segment
    send_word(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);         // extreme segment
    send_word(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_word(1'b1, Q_MIN, -1, Q_MAX, Q_MAX, 1, Q_MIN);
    send_word(1'b1, 5, -1, 5, 5, 1, 5);                                // one lsb each side
    send_word(1'b0, 0, 0, 0, 0, 0, 0);
    repeat (RAND_PER_PHASE) send_random();
    drain();

    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: begin
          // axis aligned unit normal, tolerance zero
          axis = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) n[i] = (i == axis) ? Q_ONE : 32'sd0;
          if ($urandom_range(0, 1)) n[axis] = -Q_ONE;
          write_reg(REG_ORIGIN_X, pick_coord());
          write_reg(REG_ORIGIN_Y, pick_coord());
          write_reg(REG_ORIGIN_Z, pick_coord());
          write_reg(REG_TOLERANCE, 32'd0);
        end
        2: begin
          // extremes everywhere, and a write to the spare index
          n[0] = Q_MIN;
          n[1] = Q_MAX;
          n[2] = 32'sd1;
          write_reg(REG_ORIGIN_X, Q_MAX);
          write_reg(REG_ORIGIN_Y, Q_MIN);
          write_reg(REG_ORIGIN_Z, 32'd0);
          write_reg(REG_TOLERANCE, 32'h7fff_ffff);
          write_reg(CFG_IDX_SPARE, 32'hffff_ffff);
        end
        3: begin
          for (int i = 0; i < 3; i++) n[i] = pick_coord();
          write_reg(REG_ORIGIN_X, pick_coord());
          write_reg(REG_ORIGIN_Y, pick_coord());
          write_reg(REG_ORIGIN_Z, pick_coord());
          write_reg(REG_TOLERANCE, $urandom_range(0, 65536));
        end
        default: begin
          // small origin and normal, random tolerance with the top data bit set
          for (int i = 0; i < 3; i++) n[i] = $signed($urandom_range(0, 262144)) - 131072;
          write_reg(REG_ORIGIN_X, $signed($urandom_range(0, 65536)) - 32768);
          write_reg(REG_ORIGIN_Y, $signed($urandom_range(0, 65536)) - 32768);
          write_reg(REG_ORIGIN_Z, $signed($urandom_range(0, 65536)) - 32768);
          write_reg(REG_TOLERANCE, $urandom | 32'h8000_0000);
        end
      endcase
      write_reg(REG_NORMAL_X, n[0]);
      write_reg(REG_NORMAL_Y, n[1]);
      write_reg(REG_NORMAL_Z, n[2]);
      repeat (RAND_PER_PHASE) send_random();
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
